FILE: rtl/letter_bucketed_word_counter_top_macros.svh
// assertion macros for the word counter checker
`ifndef LETTER_BUCKETED_WORD_COUNTER_TOP_MACROS_SVH
`define LETTER_BUCKETED_WORD_COUNTER_TOP_MACROS_SVH

// implication checked on every edge outside reset
`define LBWC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LBWC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lbwc_pkg.sv
`default_nettype none
package lbwc_pkg;
    localparam int NUM_BUCKETS = 26;
    localparam int BUCKET_W = 5;
    localparam int SLOT_OUT_W = 6;
    localparam int COUNT_W = 32;
    localparam int STATUS_W = 3;
    localparam logic [7:0] CHAR_LA = 8'h61;
    localparam logic [7:0] CHAR_LZ = 8'h7a;
    localparam logic [7:0] CHAR_UA = 8'h41;
    localparam logic [7:0] CHAR_UZ = 8'h5a;

    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_LETTER = 3'd4,
        ST_BAD_LENGTH = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_CMP,
        BK_NEXT,
        BK_HIT,
        BK_INSERT,
        BK_DONE
    } bk_state_t;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UA && c <= CHAR_UZ)
            r = c + 8'h20;
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/lbwc_front.sv
`default_nettype none
// collects one word per entry of the queue; words go to a char memory by write pointer
module lbwc_front #(
    parameter int WORD_LEN = 32,
    parameter int LEN_W = 6,
    parameter int QD = 2,
    parameter int QP_W = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             cmd,
    input  wire logic [7:0]       character,
    input  wire logic             last_char,
    // word queue toward the back part
    output logic                  q_valid,
    input  wire logic             q_pop,
    output logic                  q_cmd,
    output logic [LEN_W-1:0]      q_len,
    output logic [7:0]            q_first,
    input  wire logic [$clog2(WORD_LEN)-1:0] rd_idx,
    output logic [7:0]            rd_char
);
    import lbwc_pkg::*;
    localparam int IDX_W = $clog2(WORD_LEN);

    logic [7:0] chars_mem [QD*(2**IDX_W)];
    logic [QP_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QP_W:0] cnt_reg, cnt_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic q_cmd_mem [QD];
    logic [LEN_W-1:0] q_len_mem [QD];
    logic [7:0] q_first_mem [QD];
    logic [7:0] first_reg, first_next;
    logic acc, push, store;
    logic [LEN_W-1:0] fin_len;

    assign in_ready = (cnt_reg != (QP_W+1)'(QD));
    assign acc = in_valid && in_ready;
    assign store = acc && (len_reg < LEN_W'(WORD_LEN-1));
    assign push = acc && last_char;
    assign fin_len = store ? len_reg + 1'b1 : len_reg;

    always_comb
    begin
        len_next = len_reg;
        first_next = first_reg;
        if (store)
        begin
            len_next = len_reg + 1'b1;
            if (len_reg == '0)
                first_next = character;
        end
        if (push)
            len_next = '0;
        wp_next = push ? ((wp_reg == QP_W'(QD-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next = q_pop ? ((rp_reg == QP_W'(QD-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (QP_W+1)'(push) - (QP_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            len_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        if (store)
            chars_mem[{wp_reg, len_reg[IDX_W-1:0]}] <= fold_lower(character);
        if (push)
        begin
            q_cmd_mem[wp_reg] <= cmd;
            q_len_mem[wp_reg] <= fin_len;
            q_first_mem[wp_reg] <= (len_reg == '0) ? character : first_reg;
        end
        rd_char <= chars_mem[{rp_reg, rd_idx}];
    end

    assign q_valid = (cnt_reg != '0);
    assign q_cmd = q_cmd_mem[rp_reg];
    assign q_len = q_len_mem[rp_reg];
    assign q_first = q_first_mem[rp_reg];
endmodule
`default_nettype wire

FILE: rtl/lbwc_back.sv
`default_nettype none
// slot search and update engine over the word store
module lbwc_back #(
    parameter int WORD_LEN = 32,
    parameter int BUCKET_SLOTS = 64,
    parameter int LEN_W = 6
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output logic                  q_pop,
    input  wire logic             q_cmd,
    input  wire logic [LEN_W-1:0] q_len,
    input  wire logic [7:0]       q_first,
    output logic [$clog2(WORD_LEN)-1:0] rd_idx,
    input  wire logic [7:0]       rd_char,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [lbwc_pkg::STATUS_W-1:0]   status,
    output logic [lbwc_pkg::COUNT_W-1:0]    count,
    output logic [lbwc_pkg::BUCKET_W-1:0]   bucket,
    output logic [lbwc_pkg::SLOT_OUT_W-1:0] slot
);
    import lbwc_pkg::*;
    localparam int IDX_W = $clog2(WORD_LEN);
    localparam int SL_W = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
    localparam int FILL_W = $clog2(BUCKET_SLOTS + 1);
    localparam int ENT = NUM_BUCKETS * BUCKET_SLOTS;
    localparam int ENT_W = $clog2(ENT);

    logic [7:0] store_mem [ENT*(2**IDX_W)];
    logic [LEN_W-1:0] slen_mem [ENT];
    logic [COUNT_W-1:0] cnt_mem [ENT];
    logic [FILL_W-1:0] fill_reg [NUM_BUCKETS];

    bk_state_t st_reg, st_next;
    logic [BUCKET_W-1:0] bk_reg, bk_next;
    logic [SL_W-1:0] sl_reg, sl_next;
    logic [FILL_W-1:0] fl_reg, fl_next;
    logic [IDX_W:0] k_reg, k_next;
    logic mis_reg, mis_next;
    logic [7:0] sch_q;
    logic [LEN_W-1:0] slen_q;
    logic [COUNT_W-1:0] cnt_q;
    logic ov_reg, ov_next;
    logic [STATUS_W-1:0] os_reg, os_next;
    logic [COUNT_W-1:0] oc_reg, oc_next;
    logic [BUCKET_W-1:0] ob_reg, ob_next;
    logic [SLOT_OUT_W-1:0] osl_reg, osl_next;
    logic wr_cnt, wr_ins, wr_chr;
    logic [COUNT_W-1:0] wr_cval;
    logic [ENT_W-1:0] ent;
    logic [BUCKET_W-1:0] fb;
    logic fb_ok;

    assign ent = ENT_W'(bk_reg * BUCKET_SLOTS) + ENT_W'(sl_reg);
    assign rd_idx = k_reg[IDX_W-1:0];

    always_comb
    begin
        fb_ok = 1'b1;
        fb = '0;
        if (q_first >= CHAR_LA && q_first <= CHAR_LZ)
            fb = BUCKET_W'(q_first - CHAR_LA);
        else if (q_first >= CHAR_UA && q_first <= CHAR_UZ)
            fb = BUCKET_W'(q_first - CHAR_UA);
        else
            fb_ok = 1'b0;
    end

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            BK_IDLE:
                if (q_valid && !ov_reg)
                begin
                    if (q_len >= LEN_W'(WORD_LEN-1) || !fb_ok)
                        st_next = BK_DONE;
                    else
                        st_next = BK_LOOKUP;
                end
            BK_LOOKUP:
                if (fill_reg[bk_reg] == '0)
                    st_next = BK_INSERT;
                else
                    st_next = BK_CMP;
            BK_CMP:
                if (k_reg == (IDX_W+1)'(q_len) + 1'b1 || (k_reg != '0 && mis_reg))
                    st_next = BK_NEXT;
            BK_NEXT:
                if (!mis_reg && slen_q == q_len)
                    st_next = BK_HIT;
                else if (FILL_W'(sl_reg) + 1'b1 == fl_reg)
                    st_next = BK_INSERT;
                else
                    st_next = BK_CMP;
            BK_HIT:
                st_next = BK_DONE;
            BK_INSERT:
                if (q_cmd || fl_reg == FILL_W'(BUCKET_SLOTS)
                    || k_reg == (IDX_W+1)'(q_len) + 1'b1)
                    st_next = BK_DONE;
            BK_DONE:
                st_next = BK_IDLE;
            default:
                st_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        bk_next = bk_reg;
        sl_next = sl_reg;
        fl_next = fl_reg;
        k_next = k_reg;
        mis_next = mis_reg;
        ov_next = ov_reg;
        os_next = os_reg;
        oc_next = oc_reg;
        ob_next = ob_reg;
        osl_next = osl_reg;
        q_pop = 1'b0;
        wr_cnt = 1'b0;
        wr_ins = 1'b0;
        wr_chr = 1'b0;
        wr_cval = '0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                k_next = '0;
                mis_next = 1'b0;
                sl_next = '0;
                bk_next = fb;
                if (q_valid && !ov_reg)
                begin
                    oc_next = '0;
                    osl_next = '0;
                    if (q_len >= LEN_W'(WORD_LEN-1))
                    begin
                        os_next = ST_BAD_LENGTH;
                        ob_next = '0;
                    end
                    else if (!fb_ok)
                    begin
                        os_next = ST_BAD_LETTER;
                        ob_next = '0;
                    end
                end
            end
            BK_LOOKUP:
            begin
                fl_next = fill_reg[bk_reg];
                ob_next = bk_reg;
            end
            BK_CMP:
            begin
                // k steps one char; the compare works on char k-1, since both reads are registered
                k_next = k_reg + 1'b1;
                if (k_reg != '0 && k_reg <= (IDX_W+1)'(q_len) && sch_q != rd_char)
                    mis_next = 1'b1;
                if (k_reg == (IDX_W+1)'(q_len) + 1'b1 || (k_reg != '0 && mis_reg))
                    k_next = k_reg;
            end
            BK_NEXT:
            begin
                if (!(!mis_reg && slen_q == q_len))
                begin
                    sl_next = sl_reg + 1'b1;
                    k_next = '0;
                    mis_next = 1'b0;
                    if (FILL_W'(sl_reg) + 1'b1 == fl_reg)
                        k_next = '0;
                end
            end
            BK_HIT:
            begin
                osl_next = SLOT_OUT_W'(sl_reg);
                if (!q_cmd)
                begin
                    wr_cval = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
                    wr_cnt = 1'b1;
                    os_next = ST_COUNTED;
                    oc_next = wr_cval;
                end
                else
                begin
                    os_next = ST_FOUND;
                    oc_next = cnt_q;
                end
            end
            BK_INSERT:
            begin
                sl_next = SL_W'(fl_reg);
                if (q_cmd)
                    os_next = ST_NOT_FOUND;
                else if (fl_reg == FILL_W'(BUCKET_SLOTS))
                    os_next = ST_FULL;
                else
                begin
                    k_next = k_reg + 1'b1;
                    wr_chr = (k_reg != '0);
                    if (k_reg == (IDX_W+1)'(q_len) + 1'b1)
                    begin
                        k_next = k_reg;
                        wr_chr = 1'b0;
                        wr_ins = 1'b1;
                        os_next = ST_INSERTED;
                        oc_next = COUNT_W'(1);
                        osl_next = SLOT_OUT_W'(fl_reg);
                    end
                end
            end
            BK_DONE:
            begin
                q_pop = 1'b1;
                ov_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            ov_reg <= 1'b0;
            for (int b = 0; b < NUM_BUCKETS; b++)
                fill_reg[b] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            if (wr_ins)
                fill_reg[bk_reg] <= fl_reg + 1'b1;
        end
    end

    logic [ENT_W-1:0] ent_ins;
    logic [IDX_W-1:0] kw;
    assign ent_ins = ENT_W'(bk_reg * BUCKET_SLOTS) + ENT_W'(fl_reg);
    assign kw = IDX_W'(k_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        bk_reg <= bk_next;
        sl_reg <= sl_next;
        fl_reg <= fl_next;
        k_reg <= k_next;
        mis_reg <= mis_next;
        os_reg <= os_next;
        oc_reg <= oc_next;
        ob_reg <= ob_next;
        osl_reg <= osl_next;
        // stored char k is read in step with the queue side
        sch_q <= store_mem[{ent, k_reg[IDX_W-1:0]}];
        slen_q <= slen_mem[ent];
        cnt_q <= cnt_mem[ent];
        if (wr_chr)
            store_mem[{ent_ins, kw}] <= rd_char;
        if (wr_ins)
        begin
            slen_mem[ent_ins] <= q_len;
            cnt_mem[ent_ins] <= COUNT_W'(1);
        end
        if (wr_cnt)
            cnt_mem[ent] <= wr_cval;
    end

    assign out_valid = ov_reg;
    assign status = os_reg;
    assign count = oc_reg;
    assign bucket = ob_reg;
    assign slot = osl_reg;
endmodule
`default_nettype wire

FILE: rtl/letter_bucketed_word_counter_top.sv
`default_nettype none
// Word counter with 26 letter buckets. Characters arrive one beat per cycle
// while in_ready is high, with last_char marking the end of a word; the
// front collects the folded word into a two-deep word queue, so the next
// word can stream in while the back searches. The back walks the stored
// slots of the chosen bucket one character per cycle through the word store
// memory port, leaving a slot early when a character differs; a word of bad
// length or bad first letter skips the search. One result beat leaves per
// word through an output register, and the back takes the next word only
// after that beat is taken. The store itself needs no clearing pass: a
// per-bucket fill count says which slots are live.
module letter_bucketed_word_counter_top #(
    parameter int WORD_LEN = 32,
    parameter int BUCKET_SLOTS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        cmd,
    input  wire logic [7:0]  character,
    input  wire logic        last_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [lbwc_pkg::STATUS_W-1:0]   status,
    output logic [lbwc_pkg::COUNT_W-1:0]    count,
    output logic [lbwc_pkg::BUCKET_W-1:0]   bucket,
    output logic [lbwc_pkg::SLOT_OUT_W-1:0] slot
);
    import lbwc_pkg::*;
    // length field wide enough for WORD_LEN-1
    localparam int LEN_W = $clog2(WORD_LEN);

    logic q_valid, q_pop, q_cmd;
    logic [LEN_W-1:0] q_len;
    logic [7:0] q_first, rd_char;
    logic [$clog2(WORD_LEN)-1:0] rd_idx;

    // front: beat collection and word queue
    lbwc_front #(.WORD_LEN(WORD_LEN), .LEN_W(LEN_W), .QD(2), .QP_W(1)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .character(character), .last_char(last_char),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .q_len(q_len), .q_first(q_first),
        .rd_idx(rd_idx), .rd_char(rd_char)
    );

    // back: bucket search, count update, insert
    lbwc_back #(.WORD_LEN(WORD_LEN), .BUCKET_SLOTS(BUCKET_SLOTS), .LEN_W(LEN_W)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .q_len(q_len), .q_first(q_first),
        .rd_idx(rd_idx), .rd_char(rd_char),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .count(count), .bucket(bucket), .slot(slot)
    );
endmodule
`default_nettype wire

FILE: rtl/lbwc_checker.sv
`default_nettype none
`include "letter_bucketed_word_counter_top_macros.svh"
module lbwc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] status,
    input wire logic [31:0] count,
    input wire logic [4:0] bucket,
    input wire logic [5:0] slot
);
    import lbwc_pkg::*;
    // held result beat
    `LBWC_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(count), "result beat dropped")
    // error results carry no count
    `LBWC_ASSERT_IMPL(a_err, clk, rst_n,
        out_valid && (status == ST_BAD_LETTER || status == ST_BAD_LENGTH),
        count == 32'd0 && bucket == 5'd0, "error result fields")
    // inserts always start at count one
    `LBWC_ASSERT_IMPL(a_ins, clk, rst_n, out_valid && status == ST_INSERTED,
        count == 32'd1, "insert count")
    `LBWC_ASSERT_IMPL(a_rng, clk, rst_n, out_valid,
        status <= ST_FULL && bucket < BUCKET_W'(NUM_BUCKETS), "result range")
endmodule
bind letter_bucketed_word_counter_top lbwc_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .count(count), .bucket(bucket), .slot(slot)
);
`default_nettype wire
